[rtl/core/complex_integer_alu_core_macros.svh]
// Assertion macros shared by the checker of the complex integer ALU.
// Depends on nothing; included by the checker file.
`ifndef COMPLEX_INTEGER_ALU_CORE_MACROS_SVH
`define COMPLEX_INTEGER_ALU_CORE_MACROS_SVH

// Asserts an implication property on the rising clock edge, disabled in reset.
`define CIA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Asserts a next-cycle implication property, disabled in reset.
`define CIA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cia_pkg.sv]
// Package of the complex integer ALU: command codes, widths and shared types.
// Depends on nothing; used by complex_integer_alu_core and cia_mult.
package cia_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int RES_WIDTH = 33;
    localparam int CMD_WIDTH = 2;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

endpackage

[rtl/core/complex_integer_alu_core.sv]
// Throughput: one transfer per cycle; every stage advances together unless the
// output register is full and m_axis_tready is low, which holds the pipeline.
// The division pipeline, one quotient bit per stage, sets the depth.
// Reset: aresetn synchronous active low clears all valid bits; data is not reset.
// Depends on cia_pkg, cia_mult and cia_div.
module complex_integer_alu_core #(
    parameter int OperandWidth = cia_pkg::OPERAND_WIDTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // cmd, a_re, a_im, b_re, b_im from bit 0 up, zero padded to bytes.
    input  logic [((2+4*OperandWidth+7)/8)*8-1:0] s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // res_re, res_im from bit 0 up, zero padded to bytes.
    output logic [71:0]                     m_axis_tdata,
    // div_by_zero.
    output logic                            m_axis_tuser
);
    localparam int W = OperandWidth;
    localparam int RW = cia_pkg::RES_WIDTH;
    localparam int PW = 2 * W + 2;
    localparam int NW = 2 * W + 2;
    localparam int DW = 2 * W + 1;
    localparam int DivLat = NW;
    localparam int Lat = DivLat + 3;
    localparam int TW = 2 + 1 + 1 + 1 + 2 * RW;

    logic [Lat-1:0] vld_reg;
    logic en;
    logic out_vld_reg;
    logic [RW-1:0] ore_reg, oim_reg;
    logic odz_reg;

    assign en = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    logic [1:0] cmd_in;
    logic signed [W-1:0] ar, ai, br, bi;
    assign cmd_in = s_axis_tdata[1:0];
    assign ar = s_axis_tdata[2+W-1:2];
    assign ai = s_axis_tdata[2+2*W-1:2+W];
    assign br = s_axis_tdata[2+3*W-1:2+2*W];
    assign bi = s_axis_tdata[2+4*W-1:2+3*W];

    logic [1:0] cmd1_reg;
    logic signed [W:0] sre1_reg, sim1_reg;
    logic signed [PW-1:0] rr, ii, ir, ri;
    logic [W-1:0] bmr1_reg, bmi1_reg;

    cia_mult #(.OperandWidth(W), .ProdWidth(PW)) u_mult (
        .aclk(aclk), .en(en), .a_re(ar), .a_im(ai), .b_re(br), .b_im(bi),
        .rr_out(rr), .ii_out(ii), .ir_out(ir), .ri_out(ri)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd1_reg <= cmd_in;
            if (cmd_in == cia_pkg::CMD_SUB) begin
                sre1_reg <= (W+1)'(ar) - (W+1)'(br);
                sim1_reg <= (W+1)'(ai) - (W+1)'(bi);
            end else begin
                sre1_reg <= (W+1)'(ar) + (W+1)'(br);
                sim1_reg <= (W+1)'(ai) + (W+1)'(bi);
            end
            bmr1_reg <= br[W-1] ? W'(-br) : W'(br);
            bmi1_reg <= bi[W-1] ? W'(-bi) : W'(bi);
        end
    end

    // Stage 2: combine products, form denominator squares.
    logic [1:0] cmd2_reg;
    logic signed [PW-1:0] pre2_reg, pim2_reg;
    logic signed [W:0] sre2_reg, sim2_reg;
    logic [2*W-1:0] sq0_reg, sq1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd2_reg <= cmd1_reg;
            sre2_reg <= sre1_reg;
            sim2_reg <= sim1_reg;
            sq0_reg <= bmr1_reg * bmr1_reg;
            sq1_reg <= bmi1_reg * bmi1_reg;
            if (cmd1_reg == cia_pkg::CMD_DIV) begin
                pre2_reg <= rr + ii;
                pim2_reg <= ir - ri;
            end else begin
                pre2_reg <= rr - ii;
                pim2_reg <= ir + ri;
            end
        end
    end

    // Stage 3: magnitudes and denominator sum.
    logic [1:0] cmd3_reg;
    logic [NW-1:0] nm0_reg, nm1_reg;
    logic ng0_reg, ng1_reg;
    logic [DW-1:0] den3_reg;
    logic [RW-1:0] dre3_reg, dim3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd3_reg <= cmd2_reg;
            ng0_reg <= pre2_reg[PW-1];
            ng1_reg <= pim2_reg[PW-1];
            nm0_reg <= pre2_reg[PW-1] ? NW'(-pre2_reg) : NW'(pre2_reg);
            nm1_reg <= pim2_reg[PW-1] ? NW'(-pim2_reg) : NW'(pim2_reg);
            den3_reg <= DW'(sq0_reg) + DW'(sq1_reg);
            if (cmd2_reg == cia_pkg::CMD_MUL) begin
                dre3_reg <= RW'(pre2_reg);
                dim3_reg <= RW'(pim2_reg);
            end else begin
                dre3_reg <= RW'(sre2_reg);
                dim3_reg <= RW'(sim2_reg);
            end
        end
    end

    logic [NW-1:0] q0, q1;
    logic [TW-1:0] tag_in, tag_out;
    logic tdz;
    assign tdz = (den3_reg == '0);
    assign tag_in = {cmd3_reg, ng0_reg, ng1_reg, tdz, dre3_reg, dim3_reg};

    cia_div #(.NumWidth(NW), .DenWidth(DW), .TagWidth(TW)) u_div (
        .aclk(aclk), .en(en), .num0(nm0_reg), .num1(nm1_reg),
        .den(tdz ? DW'(1) : den3_reg), .tag_in(tag_in),
        .quo0(q0), .quo1(q1), .tag_out(tag_out)
    );

    logic [1:0] cmdq;
    logic ngq0, ngq1, dzq;
    logic [RW-1:0] dreq, dimq, qre, qim;
    assign {cmdq, ngq0, ngq1, dzq, dreq, dimq} = tag_out;
    assign qre = ngq0 ? RW'(-q0) : RW'(q0);
    assign qim = ngq1 ? RW'(-q1) : RW'(q1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= {vld_reg[Lat-2:0], s_axis_tvalid};
            out_vld_reg <= vld_reg[Lat-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (cmdq == cia_pkg::CMD_DIV) begin
                ore_reg <= dzq ? '0 : qre;
                oim_reg <= dzq ? '0 : qim;
                odz_reg <= dzq;
            end else begin
                ore_reg <= dreq;
                oim_reg <= dimq;
                odz_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata = {{(72-2*RW){1'b0}}, oim_reg, ore_reg};
    assign m_axis_tuser = odz_reg;
endmodule

[rtl/core/cia_mult.sv]
// Product stage of the complex integer ALU: four registered products, sign-extended to ProdWidth.
// Depends on cia_pkg.
module cia_mult #(
    parameter int OperandWidth = cia_pkg::OPERAND_WIDTH,
    parameter int ProdWidth = 2 * OperandWidth + 2
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [OperandWidth-1:0] a_re,
    input  logic signed [OperandWidth-1:0] a_im,
    input  logic signed [OperandWidth-1:0] b_re,
    input  logic signed [OperandWidth-1:0] b_im,
    output logic signed [ProdWidth-1:0]    rr_out,
    output logic signed [ProdWidth-1:0]    ii_out,
    output logic signed [ProdWidth-1:0]    ir_out,
    output logic signed [ProdWidth-1:0]    ri_out
);
    localparam int PW = 2 * OperandWidth;

    logic signed [PW-1:0] rr_reg, ii_reg, ir_reg, ri_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rr_reg <= a_re * b_re;
            ii_reg <= a_im * b_im;
            ir_reg <= a_im * b_re;
            ri_reg <= a_re * b_im;
        end
    end

    assign rr_out = ProdWidth'(rr_reg);
    assign ii_out = ProdWidth'(ii_reg);
    assign ir_out = ProdWidth'(ir_reg);
    assign ri_out = ProdWidth'(ri_reg);
endmodule

[rtl/core/cia_div.sv]
// Pipelined restoring divider of the complex integer ALU, one quotient bit per
// stage, for two magnitudes sharing one divisor. Depends on nothing else.
module cia_div #(
    parameter int NumWidth = 34,
    parameter int DenWidth = 33,
    parameter int TagWidth = 8
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [NumWidth-1:0] num0,
    input  logic [NumWidth-1:0] num1,
    input  logic [DenWidth-1:0] den,
    input  logic [TagWidth-1:0] tag_in,
    output logic [NumWidth-1:0] quo0,
    output logic [NumWidth-1:0] quo1,
    output logic [TagWidth-1:0] tag_out
);
    localparam int RW = DenWidth + 1;

    logic [NumWidth-1:0] n0_reg [NumWidth+1];
    logic [NumWidth-1:0] n1_reg [NumWidth+1];
    logic [RW-1:0]       r0_reg [NumWidth+1];
    logic [RW-1:0]       r1_reg [NumWidth+1];
    logic [DenWidth-1:0] d_reg  [NumWidth+1];
    logic [TagWidth-1:0] t_reg  [NumWidth+1];

    always_comb begin
        n0_reg[0] = num0;
        n1_reg[0] = num1;
        r0_reg[0] = '0;
        r1_reg[0] = '0;
        d_reg[0]  = den;
        t_reg[0]  = tag_in;
    end

    for (genvar s = 0; s < NumWidth; s++) begin : g_stage
        logic [RW:0] t0, t1;
        logic [RW:0] dd;
        assign dd = {2'b00, d_reg[s]};
        assign t0 = {r0_reg[s], n0_reg[s][NumWidth-1]};
        assign t1 = {r1_reg[s], n1_reg[s][NumWidth-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[s+1] <= d_reg[s];
                t_reg[s+1] <= t_reg[s];
                if (t0 >= dd) begin
                    r0_reg[s+1] <= RW'(t0 - dd);
                    n0_reg[s+1] <= {n0_reg[s][NumWidth-2:0], 1'b1};
                end else begin
                    r0_reg[s+1] <= RW'(t0);
                    n0_reg[s+1] <= {n0_reg[s][NumWidth-2:0], 1'b0};
                end
                if (t1 >= dd) begin
                    r1_reg[s+1] <= RW'(t1 - dd);
                    n1_reg[s+1] <= {n1_reg[s][NumWidth-2:0], 1'b1};
                end else begin
                    r1_reg[s+1] <= RW'(t1);
                    n1_reg[s+1] <= {n1_reg[s][NumWidth-2:0], 1'b0};
                end
            end
        end
    end

    assign quo0 = n0_reg[NumWidth];
    assign quo1 = n1_reg[NumWidth];
    assign tag_out = t_reg[NumWidth];
endmodule

[rtl/core/cia_checker.sv]
// Port-level checker of the complex integer ALU, bound to the top level.
// Depends on complex_integer_alu_core_macros.svh.
`include "complex_integer_alu_core_macros.svh"
module cia_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    `CIA_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `CIA_ASSERT_IMP(a_ready_free, aclk, aresetn, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
    `CIA_ASSERT_IMP(a_dz_zero, aclk, aresetn, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "divide by zero result not zero")
    `CIA_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_axis_tvalid, m_axis_tdata[71:66] == '0, "padding bits set")
endmodule

bind complex_integer_alu_core cia_checker u_cia_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
